@@ rtl/core/elevator_scan_scheduler_defines.svh @@
// Assertion macros for the elevator SCAN scheduler RTL.
// Expects clk and rst in the scope of the module that uses them.
`ifndef ELEVATOR_SCAN_SCHEDULER_DEFINES_SVH
`define ELEVATOR_SCAN_SCHEDULER_DEFINES_SVH

`ifndef ASSERT_OFF
// condition holds at every edge out of reset
`define ESS_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("ess assertion failed");
// antecedent implies consequent in the same cycle
`define ESS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ess assertion failed");
// antecedent implies consequent in the next cycle
`define ESS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ess assertion failed");
`else
`define ESS_ASSERT_ALWAYS(label, cond)
`define ESS_ASSERT_IMPL(label, ante, cons)
`define ESS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/core/ess_pkg.sv @@
// Types and codes shared by the elevator SCAN scheduler.
// No dependencies.
`default_nettype none

package ess_pkg;

  localparam int FLOORS_DEF = 8;
  localparam int FLOOR_W    = 4;
  localparam int KIND_W     = 2;
  localparam int MOTION_W   = 2;

  // item operation
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // request kinds, also the per-floor call codes
  localparam logic [KIND_W-1:0] KIND_DEST = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DOWN = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BOTH = 2'd3;

  // car motion
  localparam logic [MOTION_W-1:0] MOT_NONE = 2'd0;
  localparam logic [MOTION_W-1:0] MOT_UP   = 2'd1;
  localparam logic [MOTION_W-1:0] MOT_DOWN = 2'd2;

  typedef struct packed {
    logic               op;
    logic [FLOOR_W-1:0] request_floor;
    logic [KIND_W-1:0]  request_kind;
  } req_word_t;

  typedef struct packed {
    logic [FLOOR_W-1:0]  floor;
    logic [MOTION_W-1:0] motion;
    logic                door_cycle;
    logic                heading_down;
    logic                parked;
  } res_word_t;

endpackage

`default_nettype wire

@@ rtl/core/elevator_scan_scheduler.sv @@
// Elevator SCAN scheduler: per-floor calls and destinations, one sweep step per tick.
// A request word passes the input register, then the result register.
// One word per cycle while res_stall does not hold the result; the state update is
// combinational between the two registers; priority encoders give the sweep bounds.
// Reset (rst, synchronous): car at floor 1, up sweep, no calls, park floor 1.
// Uses ess_pkg and elevator_scan_scheduler_defines.svh.
`default_nettype none
`include "elevator_scan_scheduler_defines.svh"

module elevator_scan_scheduler
  import ess_pkg::*;
#(
  parameter int FLOORS = FLOORS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire req_word_t          req,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output res_word_t               res,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [FLOOR_W-1:0] cfg_data
);

  localparam int FW = $clog2(FLOORS + 1);

  // highest set floor, 0 when none
  function automatic logic [FW-1:0] top_of(input logic [FLOORS:1] v);
    logic [FW-1:0] r;
    r = '0;
    for (int f = 1; f <= FLOORS; f++) begin
      if (v[f]) r = FW'(f);
    end
    return r;
  endfunction

  // lowest set floor, 0 when none
  function automatic logic [FW-1:0] bottom_of(input logic [FLOORS:1] v);
    logic [FW-1:0] r;
    r = '0;
    for (int f = FLOORS; f >= 1; f--) begin
      if (v[f]) r = FW'(f);
    end
    return r;
  endfunction

  // state
  logic [FLOOR_W-1:0] park;
  logic [FW-1:0]      cur;
  logic               sweep;
  logic [KIND_W-1:0]  call_code [1:FLOORS];
  logic               dest_mark [1:FLOORS];

  // input register
  logic      in_valid;
  req_word_t in_word;
  logic      advance;
  logic      exec;

  // next-state logic
  logic [FW-1:0]       cur_next;
  logic                sweep_next;
  logic [KIND_W-1:0]   call_next [1:FLOORS];
  logic                dest_next [1:FLOORS];
  logic [MOTION_W-1:0] mot;
  logic                door;
  logic [FLOORS:1]     pend;
  logic [FLOORS:1]     pend_srv;
  logic [FLOORS:1]     pend_next;
  logic [KIND_W-1:0]   srv_code;
  logic [FW-1:0]       park_used;
  logic [FW-1:0]       top0;
  logic [FW-1:0]       bot0;
  logic [FW-1:0]       top1;
  logic [FW-1:0]       bot1;
  logic [FW-1:0]       rf;
  logic                rf_ok;

  assign cfg_ready = 1'b1;
  assign advance   = !res_valid || !res_stall;
  assign exec      = in_valid && advance;
  assign req_stall = in_valid && !advance;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      park <= FLOOR_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      park <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (req_valid && !req_stall) begin
      in_word <= req;
    end
  end

  // call code left at the car floor once the current sweep serves it
  assign srv_code = sweep ? (call_code[cur] & ~KIND_DOWN) : (call_code[cur] & ~KIND_UP);

  // pending floors now and after serving the car floor
  always_comb begin
    for (int f = 1; f <= FLOORS; f++) begin
      pend[f]     = (call_code[f] != KIND_DEST) || dest_mark[f];
      pend_srv[f] = pend[f];
    end
    pend_srv[cur] = (srv_code != KIND_DEST);
  end

  // pending floors after this word
  always_comb begin
    for (int f = 1; f <= FLOORS; f++) begin
      pend_next[f] = (call_next[f] != KIND_DEST) || dest_next[f];
    end
  end

  // park floor clamped into the building
  always_comb begin
    if (park == '0) begin
      park_used = FW'(1);
    end else if (32'(park) > FLOORS) begin
      park_used = FW'(FLOORS);
    end else begin
      park_used = FW'(park);
    end
  end

  // sweep bounds; an empty building reads as the park floor
  always_comb begin
    top0 = top_of(pend);
    bot0 = bottom_of(pend);
    top1 = top_of(pend_srv);
    bot1 = bottom_of(pend_srv);
    if (top0 == '0) top0 = park_used;
    if (bot0 == '0) bot0 = park_used;
    if (top1 == '0) top1 = park_used;
    if (bot1 == '0) bot1 = park_used;
  end

  assign rf_ok = (in_word.request_floor != '0) && (32'(in_word.request_floor) <= FLOORS);
  assign rf    = FW'(in_word.request_floor);

  // request registration and sweep step
  always_comb begin
    call_next  = call_code;
    dest_next  = dest_mark;
    cur_next   = cur;
    sweep_next = sweep;
    mot        = MOT_NONE;
    door       = 1'b0;
    if (in_word.op == OP_REQUEST) begin
      if (rf_ok) begin
        if (in_word.request_kind != KIND_DEST) begin
          call_next[rf] = in_word.request_kind;
        end else begin
          dest_next[rf] = 1'b1;
        end
      end
    end else if (!sweep) begin
      // up sweep: serve up calls, clearing bit 0 drops the up part
      if (cur > top0) begin
        sweep_next = 1'b1;
      end else begin
        if (call_code[cur] == KIND_UP || call_code[cur] == KIND_BOTH) begin
          call_next[cur] = call_code[cur] & ~KIND_UP;
          door = 1'b1;
        end
        if (dest_mark[cur]) begin
          dest_next[cur] = 1'b0;
          door = 1'b1;
        end
        if (cur < top1) begin
          cur_next = cur + 1'b1;
          mot      = MOT_UP;
        end else begin
          sweep_next = 1'b1;
        end
      end
    end else begin
      // down sweep: serve down calls, clearing bit 1 drops the down part
      if (cur < bot0) begin
        sweep_next = 1'b0;
      end else begin
        if (call_code[cur] == KIND_DOWN || call_code[cur] == KIND_BOTH) begin
          call_next[cur] = call_code[cur] & ~KIND_DOWN;
          door = 1'b1;
        end
        if (dest_mark[cur]) begin
          dest_next[cur] = 1'b0;
          door = 1'b1;
        end
        if (cur > bot1) begin
          cur_next = cur - 1'b1;
          mot      = MOT_DOWN;
        end else begin
          sweep_next = 1'b0;
        end
      end
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= FW'(1);
      sweep     <= 1'b0;
      res_valid <= 1'b0;
      for (int f = 1; f <= FLOORS; f++) begin
        call_code[f] <= KIND_DEST;
        dest_mark[f] <= 1'b0;
      end
    end else begin
      if (exec) begin
        cur       <= cur_next;
        sweep     <= sweep_next;
        call_code <= call_next;
        dest_mark <= dest_next;
        res_valid <= 1'b1;
      end else if (advance) begin
        res_valid <= 1'b0;
      end
    end
    if (exec) begin
      res.floor        <= FLOOR_W'(cur_next);
      res.motion       <= mot;
      res.door_cycle   <= door;
      res.heading_down <= sweep_next;
      res.parked       <= ~|pend_next;
    end
  end

  // checks
  `ESS_ASSERT_ALWAYS(a_floor_in_range, (cur != '0) && (32'(cur) <= FLOORS))
  `ESS_ASSERT_NEXT(a_move_up_one, exec && (mot == MOT_UP), cur == $past(cur) + 1'b1)
  `ESS_ASSERT_IMPL(a_request_still, exec && (in_word.op == OP_REQUEST),
                   (mot == MOT_NONE) && !door && (cur_next == cur))
  `ESS_ASSERT_IMPL(a_parked_matches, res_valid, res.parked == ~|pend)

endmodule

`default_nettype wire
